@@ design/led_twinkle_envelope_defines.svh @@
// Assertion macros shared by the led_twinkle_envelope RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef LED_TWINKLE_ENVELOPE_DEFINES_SVH
`define LED_TWINKLE_ENVELOPE_DEFINES_SVH

`ifndef ASSERT_OFF
// prop must hold at every edge outside reset
`define LTE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lte assertion failed");
// when a holds, b must hold in the next cycle
`define LTE_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("lte assertion failed");
`else
`define LTE_ASSERT(label, clk, rst, prop)
`define LTE_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

@@ design/lte_pkg.sv @@
// Shared types, widths, constant tables for the LED twinkle envelope.
// No dependencies; imported by every module of the block but lte_ram.
package lte_pkg;

  localparam int NUM_PIXELS = 64;
  localparam int IDX_W      = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

  // field widths
  localparam int PIX_W   = 6;
  localparam int PAT_W   = 4;
  localparam int ROLL_W  = 7;
  localparam int LEVEL_W = 8;
  localparam int LIFE_W  = 10;
  localparam int HALF_W  = 9;                  // half of the longest life, 500
  localparam int PROD_W  = HALF_W + LEVEL_W;   // d * span
  localparam int ENTRY_W = PAT_W + LIFE_W;

  // divider: quotient never exceeds span, so one step per level bit
  localparam int DIV_STEPS = LEVEL_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [LEVEL_W-1:0] BASE_RESET  = 8'h30;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'hFF;
  localparam logic [LIFE_W-1:0]  DECAY_FLOOR = 10'd2;

  // opcodes
  localparam logic OP_SPAWN  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } lte_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul_load;
    logic div_step;
    logic div_last;
    logic out_load;
  } lte_cmd_t;

  typedef struct packed {
    logic env_go;
  } lte_stat_t;

  function automatic logic [LIFE_W-1:0] life_of_class(input logic [1:0] cls);
    logic [LIFE_W-1:0] life;
    unique case (cls)
      2'd0: life = 10'd120;
      2'd1: life = 10'd200;
      2'd2: life = 10'd300;
      2'd3: life = 10'd1000;
      default: life = '0;
    endcase
    return life;
  endfunction

  function automatic logic [ROLL_W-1:0] chance_of_class(input logic [1:0] cls);
    logic [ROLL_W-1:0] chance;
    unique case (cls)
      2'd0: chance = 7'd0;
      2'd1: chance = 7'd1;
      2'd2: chance = 7'd1;
      2'd3: chance = 7'd5;
      default: chance = '0;
    endcase
    return chance;
  endfunction

endpackage

@@ design/lte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/lte_ctrl.sv @@
// Sequencer for the twinkle envelope: item handshake, step count, result beat.
// Depends on lte_pkg and led_twinkle_envelope_defines.svh.
`include "led_twinkle_envelope_defines.svh"

module lte_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lte_pkg::lte_stat_t stat,
  output lte_pkg::lte_cmd_t  cmd
);
  import lte_pkg::*;

  lte_state_t        state, state_next;
  logic [STEP_W-1:0] step;
  logic              step_last;
  logic              out_free;

  assign step_last = (step == STEP_W'(DIV_STEPS - 1));
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_READ;
      ST_READ: state_next = stat.env_go ? ST_MUL : ST_DONE;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (step_last) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == ST_IDLE);
    cmd.capture  = in_valid && (state == ST_IDLE);
    cmd.eval     = (state == ST_READ);
    cmd.mul_load = (state == ST_MUL);
    cmd.div_step = (state == ST_DIV);
    cmd.div_last = (state == ST_DIV) && step_last;
    cmd.out_load = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.mul_load) begin
        step <= '0;
      end else if (cmd.div_step) begin
        step <= step + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LTE_ASSERT_NEXT(a_capture_reads, clk, rst, cmd.capture, state == ST_READ)
  `LTE_ASSERT_NEXT(a_div_ends, clk, rst, cmd.div_last, state == ST_DONE)
  `LTE_ASSERT(a_busy_not_ready, clk, rst, (state != ST_IDLE) |-> !in_ready)

endmodule

@@ design/lte_datapath.sv @@
// Datapath: pixel state RAM with valid bits, decay, envelope multiply and
// restoring divider, result register. Depends on lte_pkg, lte_ram, defines.
`include "led_twinkle_envelope_defines.svh"

module lte_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  lte_pkg::lte_cmd_t            cmd,
  output lte_pkg::lte_stat_t           stat,
  input  logic                         cfg_we,
  input  logic [lte_pkg::LEVEL_W-1:0]  cfg_wdata,
  input  logic                         opcode,
  input  logic [lte_pkg::PIX_W-1:0]    pixel_index,
  input  logic [lte_pkg::PAT_W-1:0]    pattern,
  input  logic [lte_pkg::ROLL_W-1:0]   blink_roll,
  output logic [lte_pkg::LEVEL_W-1:0]  level,
  output logic                         accepted
);
  import lte_pkg::*;

  // captured item
  logic              op_q;
  logic [IDX_W-1:0]  idx_q;
  logic              idx_ok_q;
  logic [PAT_W-1:0]  pat_q;
  logic [ROLL_W-1:0] roll_q;

  logic [LEVEL_W-1:0]    base_level;
  logic [NUM_PIXELS-1:0] live;         // entry written since reset

  logic [ENTRY_W-1:0] rd_data, wr_data;
  logic               wr_en;
  logic [IDX_W-1:0]   raddr;

  logic [LIFE_W-1:0] ent_life, life_dec, maxl;
  logic [PAT_W-1:0]  ent_pat;
  logic              start;
  logic [HALF_W-1:0] half_next, d_next;

  logic [HALF_W-1:0]  half_q, d_q, rem_q, rem_next;
  logic [LEVEL_W-1:0] lo_q, quo_q, quo_next, span;
  logic [PROD_W-1:0]  prod;
  logic [HALF_W:0]    trial;
  logic               ge;

  logic [LEVEL_W-1:0] res_level;
  logic               res_acc;

  assign raddr = cmd.capture ? IDX_W'(pixel_index) : idx_q;

  lte_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_PIXELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_q),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // entry lookup and update, in the cycle after capture
  always_comb begin
    ent_life = live[idx_q] ? rd_data[LIFE_W-1:0] : '0;
    ent_pat  = live[idx_q] ? rd_data[ENTRY_W-1:LIFE_W] : '0;
    start    = idx_ok_q && (ent_life == '0);
    life_dec = (ent_life > DECAY_FLOOR) ? ent_life - 1'b1 : '0;
    wr_en    = cmd.eval && ((op_q == OP_RENDER) ? idx_ok_q : start);
    wr_data  = (op_q == OP_RENDER) ? {ent_pat, life_dec}
                                   : {pat_q, life_of_class(pat_q[1:0])};

    maxl      = life_of_class(ent_pat[1:0]);
    half_next = HALF_W'(maxl >> 1);
    if (life_dec > LIFE_W'(half_next)) begin
      d_next = (life_dec <= maxl) ? HALF_W'(maxl - life_dec) : '0;
    end else begin
      d_next = HALF_W'(life_dec);
    end

    stat.env_go = (op_q == OP_RENDER) && idx_ok_q && (life_dec != '0) &&
                  (roll_q > chance_of_class(ent_pat[3:2]));
  end

  // multiply and divide step
  assign span     = LEVEL_MAX - base_level;
  assign prod     = PROD_W'(d_q) * PROD_W'(span);
  assign trial    = {rem_q, lo_q[LEVEL_W-1]};
  assign ge       = (trial >= {1'b0, half_q});
  assign rem_next = ge ? HALF_W'(trial - {1'b0, half_q}) : HALF_W'(trial);
  assign quo_next = {quo_q[LEVEL_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_level <= BASE_RESET;
      live       <= '0;
    end else begin
      if (cfg_we) begin
        base_level <= cfg_wdata;
      end
      if (wr_en) begin
        live[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= opcode;
      idx_q    <= IDX_W'(pixel_index);
      idx_ok_q <= (int'(pixel_index) < NUM_PIXELS);
      pat_q    <= pattern;
      roll_q   <= blink_roll;
    end
    if (cmd.eval) begin
      d_q       <= d_next;
      half_q    <= half_next;
      res_level <= (op_q == OP_RENDER) ? base_level : '0;
      res_acc   <= (op_q == OP_SPAWN) && start;
    end
    if (cmd.mul_load) begin
      // top bits are already below the divisor since d never exceeds half
      rem_q <= prod[PROD_W-1:LEVEL_W];
      lo_q  <= prod[LEVEL_W-1:0];
      quo_q <= '0;
    end
    if (cmd.div_step) begin
      rem_q <= rem_next;
      lo_q  <= {lo_q[LEVEL_W-2:0], 1'b0};
      quo_q <= quo_next;
      if (cmd.div_last) begin
        res_level <= base_level + quo_next;
      end
    end
    if (cmd.out_load) begin
      level    <= res_level;
      accepted <= res_acc;
    end
  end

  `LTE_ASSERT(a_rem_below_half, clk, rst, cmd.div_step |-> (rem_q < half_q))
  `LTE_ASSERT_NEXT(a_spawn_marks_live, clk, rst, cmd.eval && (op_q == OP_SPAWN) && idx_ok_q, live[idx_q])

endmodule

@@ design/led_twinkle_envelope.sv @@
// Top level of the LED twinkle envelope block.
// Depends on lte_pkg, lte_ctrl, lte_datapath (and lte_ram below it).
//
// Twinkle envelope for a strip of 64 pixels. Each pixel holds a 10-bit life
// counter and a 4-bit pattern in a small RAM; valid bits make every pixel
// read as idle after reset, so no clearing pass is needed. An opcode 0 beat
// spawns a twinkle on an idle pixel (accepted=1, level=0); an opcode 1 beat
// decays the pixel and returns its grey level. An active pixel whose roll
// beats its blink chance gets base_level + floor(d*(255-base_level)/half),
// a triangle over its life; everything else gets base_level. Spawns and
// plain renders go from the capture to a read state and then to the done
// state, which loads the result register; an envelope render passes a
// multiply state and an 8-step restoring divider (one quotient bit per
// cycle) between the read and done states. One item is in flight at a time;
// in_ready returns as soon as the result is registered, so the next beat
// may be taken while the previous result still waits for out_ready; that
// item then holds in its last cycle until the result register frees up.
// cfg_we writes base_level (reset 0x30); write it only while the block is
// idle.
module led_twinkle_envelope (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_we,
  input  logic [lte_pkg::LEVEL_W-1:0]  cfg_wdata,
  // input beat
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [lte_pkg::PIX_W-1:0]    pixel_index,
  input  logic [lte_pkg::PAT_W-1:0]    pattern,
  input  logic [lte_pkg::ROLL_W-1:0]   blink_roll,
  // result beat
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lte_pkg::LEVEL_W-1:0]  level,
  output logic                         accepted
);
  import lte_pkg::*;

  lte_cmd_t  cmd;
  lte_stat_t stat;

  // sequencer: handshakes, divider step count
  lte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // state RAM, envelope arithmetic, result register
  lte_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .opcode      (opcode),
    .pixel_index (pixel_index),
    .pattern     (pattern),
    .blink_roll  (blink_roll),
    .level       (level),
    .accepted    (accepted)
  );

endmodule
